// ----- rtl/ima_pkg.sv -----
// Package with the IMA ADPCM step table, index moves, limits and direction codes.
`default_nettype none
package ima_pkg;

	localparam int unsigned StepWidth = 15;
	localparam int unsigned IdxWidth = 7;

	localparam logic [IdxWidth-1:0] MaxIndex = 7'd88;
	localparam logic signed [15:0] PcmMax = 16'sh7FFF;
	localparam logic signed [15:0] PcmMin = 16'sh8000;

	typedef logic [StepWidth-1:0] step_t;
	typedef logic [IdxWidth-1:0] idx_t;

	typedef enum logic {
		DIR_ENCODE = 1'b0,
		DIR_DECODE = 1'b1
	} dir_t;

	localparam step_t StepTable [0:88] = '{
		15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
		15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
		15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
		15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
		15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
		15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
		15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
		15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749,
		15'd3024, 15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358,
		15'd5894, 15'd6484, 15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442,
		15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500,
		15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
	};

	// Indexes above the top of the table read as the last entry.
	function automatic step_t step_size(input idx_t idx);
		step_t s;
		if (idx > MaxIndex) begin
			s = StepTable[MaxIndex];
		end else begin
			s = StepTable[idx];
		end
		return s;
	endfunction

	function automatic logic signed [4:0] idx_move(input logic [2:0] mag);
		logic signed [4:0] m;
		unique case (mag)
			3'd4: m = 5'sd2;
			3'd5: m = 5'sd4;
			3'd6: m = 5'sd6;
			3'd7: m = 5'sd8;
			default: m = -5'sd1;
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/ima_adpcm_codec.sv -----
// Top level of the IMA ADPCM 4-bit encoder and decoder.
`default_nettype none
// IMA ADPCM codec: in encode direction each 16-bit sample request yields a 4-bit code
// plus the reconstructed sample, in decode direction each code yields the decoded
// sample (code_out reads zero). One request is taken every clock cycle unless a
// stalled result backs up the pipe. A request sits in the input register while the
// step table lookup, the three step comparisons and the saturating predictor and index
// update run, and the output register is loaded from it once the output side can
// advance. The predictor and step index are held in registers that this update reads
// and writes, so consecutive requests chain without gaps. A stalled result holds the
// output register, and the input stalls only once the input register is full as well.
// Write direction only while idle.
module ima_adpcm_codec (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire               cfg_data,
	input  wire               in_valid,
	output logic              in_stall,
	input  wire signed [15:0] pcm_sample,
	input  wire        [3:0]  code_in,
	output logic              out_valid,
	input  wire               out_stall,
	output logic       [3:0]  code_out,
	output logic signed [15:0] sample_out
);
	import ima_pkg::*;

	dir_t dir_q;
	logic signed [15:0] pred_q;
	idx_t idx_q;

	logic valid_s1;
	logic signed [15:0] sample_s1;
	logic [3:0] code_s1;
	logic valid_s2;

	logic adv;
	logic load_s1;

	step_t step;
	logic signed [16:0] diff;
	logic [16:0] diff_abs;
	logic [15:0] mag;
	logic [15:0] rem1;
	logic [15:0] rem2;
	logic enc_neg;
	logic c2, c1, c0;
	logic [3:0] code;
	logic [15:0] dq;
	logic signed [17:0] p_sum;
	logic signed [15:0] p_new;
	logic signed [7:0] idx_sum;
	idx_t idx_new;

	assign cfg_ready = 1'b1;

	assign adv = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;
	assign load_s1 = in_valid && !in_stall;

	// Encode: sign of the difference, then three successive step comparisons; decode takes the input code.
	always_comb begin
		step = step_size(idx_q);
		diff = 17'(sample_s1) - 17'(pred_q);
		enc_neg = diff[16];
		diff_abs = enc_neg ? 17'(-diff) : 17'(diff);
		mag = diff_abs[15:0];
		c2 = mag >= 16'(step);
		rem1 = c2 ? mag - 16'(step) : mag;
		c1 = rem1 >= 16'(step >> 1);
		rem2 = c1 ? rem1 - 16'(step >> 1) : rem1;
		c0 = rem2 >= 16'(step >> 2);
		if (dir_q == DIR_ENCODE) begin
			code = {enc_neg, c2, c1, c0};
		end else begin
			code = code_s1;
		end
	end

	// Predictor and index update shared by both directions.
	always_comb begin
		dq = 16'(step >> 3);
		if (code[2]) begin
			dq = dq + 16'(step);
		end
		if (code[1]) begin
			dq = dq + 16'(step >> 1);
		end
		if (code[0]) begin
			dq = dq + 16'(step >> 2);
		end
		if (code[3]) begin
			p_sum = 18'(pred_q) - $signed({2'b00, dq});
		end else begin
			p_sum = 18'(pred_q) + $signed({2'b00, dq});
		end
		priority if (p_sum > 18'(PcmMax)) begin
			p_new = PcmMax;
		end else if (p_sum < 18'(PcmMin)) begin
			p_new = PcmMin;
		end else begin
			p_new = p_sum[15:0];
		end
		idx_sum = $signed({1'b0, idx_q}) + 8'(idx_move(code[2:0]));
		priority if (idx_sum < 8'sd0) begin
			idx_new = '0;
		end else if (idx_sum > $signed({1'b0, MaxIndex})) begin
			idx_new = MaxIndex;
		end else begin
			idx_new = idx_sum[IdxWidth-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
			pred_q <= '0;
			idx_q <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				dir_q <= dir_t'(cfg_data);
			end
			if (adv) begin
				valid_s1 <= load_s1;
				valid_s2 <= valid_s1;
			end else if (load_s1) begin
				valid_s1 <= 1'b1;
			end
			if (valid_s1 && adv) begin
				pred_q <= p_new;
				idx_q <= idx_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sample_s1 <= pcm_sample;
			code_s1 <= code_in;
		end
		if (valid_s1 && adv) begin
			code_out <= (dir_q == DIR_ENCODE) ? code : 4'd0;
			sample_out <= p_new;
		end
	end

	assign out_valid = valid_s2;

endmodule
`default_nettype wire

// ----- rtl/ima_chk.sv -----
// Port-level checker for the IMA ADPCM codec, bound to the top level.
`default_nettype none
module ima_chk (
	input wire               clk,
	input wire               arst_n,
	input wire               cfg_valid,
	input wire               cfg_ready,
	input wire               cfg_data,
	input wire               in_valid,
	input wire               in_stall,
	input wire               out_valid,
	input wire               out_stall,
	input wire        [3:0]  code_out,
	input wire signed [15:0] sample_out
);
	import ima_pkg::*;

	dir_t dir_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			dir_q <= dir_t'(cfg_data);
		end
	end

	// A held result must not change until the downstream side takes it.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(code_out) && $stable(sample_out))
		else $error("result changed while stalled");

	// The input side only backs up when the output register is full and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// A request flowing through an unstalled pipe shows up at the output as a valid result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_stall ##1 !out_stall |=> out_valid)
		else $error("result missing two cycles after request");

	// Decode results carry no code.
	a_decode_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dir_q == DIR_DECODE |-> code_out == 4'd0)
		else $error("nonzero code in decode direction");

endmodule

bind ima_adpcm_codec ima_chk u_ima_chk (.*);
`default_nettype wire

// ----- verif/tb_ima_adpcm_codec.sv -----
// Self-checking testbench for the IMA ADPCM codec: directed rows, then random streams.
module tb_ima_adpcm_codec;
	import ima_pkg::*;

	typedef struct packed {
		logic [3:0]         code;
		logic signed [15:0] sample;
	} adpcm_res_t;

	typedef struct {
		dir_t               dir;
		logic signed [15:0] pcm;
		logic [3:0]         nib;
		bit                 typed;
		adpcm_res_t         want;
	} vec_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic               cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic signed [15:0] pcm_sample;
	logic [3:0]         code_in;
	logic               out_valid;
	logic               out_stall;
	logic [3:0]         code_out;
	logic signed [15:0] sample_out;

	// Shadow of the codec state, advanced once per accepted request.
	dir_t               cur_dir;
	logic signed [15:0] pred_value;
	idx_t               step_pos;

	adpcm_res_t pending_results [$];
	vec_t       directed_vecs [$];
	int         mismatch_count = 0;
	int         send_idle_pct = 0;
	int         recv_idle_pct = 0;
	bit         stall_burst_due = 1'b0;

	ima_adpcm_codec u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pcm_sample(pcm_sample),
		.code_in   (code_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.code_out  (code_out),
		.sample_out(sample_out)
	);

	always #1 clk = ~clk;

	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic flag_mismatch(input string what, input int got, input int want);
		$display("ERROR %s: got %0d, expected %0d", what, got, want);
		mismatch_count++;
	endtask

	// Encodes or decodes one request and moves the shadow predictor and step index.
	function automatic adpcm_res_t adpcm_advance(input logic signed [15:0] pcm,
			input logic [3:0] nib);
		int         step;
		int         diff;
		int         delta;
		int         p;
		int         idx;
		logic [3:0] c;
		adpcm_res_t r;
		idx = (step_pos > MaxIndex) ? int'(MaxIndex) : int'(step_pos);
		step = int'(StepTable[idx]);
		if (cur_dir == DIR_ENCODE) begin
			c = 4'd0;
			diff = int'(pcm) - int'(pred_value);
			if (diff < 0) begin
				c[3] = 1'b1;
				diff = -diff;
			end
			if (diff >= step) begin
				c[2] = 1'b1;
				diff -= step;
			end
			if (diff >= (step >> 1)) begin
				c[1] = 1'b1;
				diff -= step >> 1;
			end
			if (diff >= (step >> 2)) begin
				c[0] = 1'b1;
			end
		end else begin
			c = nib;
		end
		delta = step >> 3;
		if (c[2]) delta += step;
		if (c[1]) delta += step >> 1;
		if (c[0]) delta += step >> 2;
		p = c[3] ? int'(pred_value) - delta : int'(pred_value) + delta;
		if (p < int'(PcmMin)) p = int'(PcmMin);
		if (p > int'(PcmMax)) p = int'(PcmMax);
		pred_value = p[15:0];
		// Small magnitudes move the step index down by one, large ones move it up by 2 to 8.
		if (c[2]) begin
			idx += 2 * int'(c[1:0]) + 2;
		end else begin
			idx -= 1;
		end
		if (idx < 0) idx = 0;
		if (idx > int'(MaxIndex)) idx = int'(MaxIndex);
		step_pos = idx[IdxWidth-1:0];
		r.code = (cur_dir == DIR_ENCODE) ? c : 4'd0;
		r.sample = p[15:0];
		return r;
	endfunction

	task automatic offer_item(input logic signed [15:0] pcm, input logic [3:0] nib,
			input bit typed, input adpcm_res_t typed_res);
		adpcm_res_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		pcm_sample <= pcm;
		code_in <= nib;
		do @(posedge clk); while (in_stall);
		r = adpcm_advance(pcm, nib);
		pending_results.push_back(typed ? typed_res : r);
	endtask

	task automatic wait_idle;
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_direction(input dir_t d);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_dir = d;
	endtask

	task automatic add_row(input dir_t d, input logic signed [15:0] pcm, input logic [3:0] nib,
			input bit typed, input logic signed [15:0] want_sample);
		vec_t v;
		v.dir = d;
		v.pcm = pcm;
		v.nib = nib;
		v.typed = typed;
		v.want.code = 4'd0;
		v.want.sample = want_sample;
		directed_vecs.push_back(v);
	endtask

	// Result side: checks every accepted result and applies random or long back-pressure.
	initial begin
		adpcm_res_t want;
		int         hold_left;
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result with none pending, sample_out", sample_out, 0);
				end else begin
					want = pending_results.pop_front();
					if (code_out !== want.code)
						flag_mismatch("code_out", code_out, want.code);
					if (sample_out !== want.sample)
						flag_mismatch("sample_out", sample_out, want.sample);
				end
			end
			if (stall_burst_due) begin
				stall_burst_due = 1'b0;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		vec_t               v;
		int                 mode;
		int                 blk;
		int                 n;
		int                 k;
		int                 walk;
		logic [3:0]         nib;
		logic signed [15:0] pcm;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		in_valid = 1'b0;
		pcm_sample = 16'sd0;
		code_in = 4'd0;
		cur_dir = DIR_ENCODE;
		pred_value = 16'sd0;
		step_pos = '0;
		walk = 0;

		// Fresh state decodes a zero code to zero. Eleven largest codes walk the
		// step index to the top, so the twelfth saturates high; two largest negative
		// codes then saturate low, and a bare sign bit stays pinned there.
		add_row(DIR_DECODE, 16'sh7FFF, 4'd0, 1'b1, 16'sd0);
		for (k = 0; k < 11; k++) add_row(DIR_DECODE, 16'(k * 5957), 4'd7, 1'b0, 16'sd0);
		add_row(DIR_DECODE, 16'sh8000, 4'd7, 1'b1, PcmMax);
		add_row(DIR_DECODE, 16'sh0000, 4'd15, 1'b0, 16'sd0);
		add_row(DIR_DECODE, 16'shFFFF, 4'd15, 1'b1, PcmMin);
		add_row(DIR_DECODE, 16'sh1234, 4'd8, 1'b1, PcmMin);
		add_row(DIR_ENCODE, PcmMax, 4'd15, 1'b0, 16'sd0);
		add_row(DIR_ENCODE, PcmMin, 4'd0, 1'b0, 16'sd0);
		add_row(DIR_ENCODE, 16'sd0, 4'd7, 1'b0, 16'sd0);
		add_row(DIR_ENCODE, -16'sd1, 4'd8, 1'b0, 16'sd0);
		add_row(DIR_ENCODE, 16'sh5A5A, 4'd5, 1'b0, 16'sd0);
		add_row(DIR_ENCODE, 16'shA5A5, 4'd10, 1'b0, 16'sd0);
		add_row(DIR_ENCODE, 16'sd1, 4'd3, 1'b0, 16'sd0);
		add_row(DIR_DECODE, PcmMax, 4'd3, 1'b0, 16'sd0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_vecs[i]) begin
			v = directed_vecs[i];
			if (v.dir != cur_dir) begin
				wait_idle();
				set_direction(v.dir);
			end
			offer_item(v.pcm, v.nib, v.typed, v.want);
		end

		for (mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 34 : (mode == 1) ? 71 : 0;
			recv_idle_pct = (mode == 0) ? 71 : (mode == 1) ? 34 : 0;
			for (blk = 0; blk < 4; blk++) begin
				wait_idle();
				set_direction(blk[0] ? DIR_DECODE : DIR_ENCODE);
				// With nobody idling, a long receiver hold lets the pipeline fill up.
				if (mode == 2 && blk == 0) stall_burst_due = 1'b1;
				for (n = 0; n < 33; n++) begin
					k = $urandom_range(9);
					if (cur_dir == DIR_ENCODE) begin
						// A wandering waveform, with jumps, full-range noise and hits on either rail.
						if (k < 4) walk += $urandom_range(2000) - 1000;
						else if (k < 6) walk += $urandom_range(40000) - 20000;
						else if (k < 8) walk = int'($signed(16'($urandom)));
						else if (k == 8) walk = $urandom_range(1) ? int'(PcmMax) : int'(PcmMin);
						if (walk > int'(PcmMax)) walk = int'(PcmMax);
						if (walk < int'(PcmMin)) walk = int'(PcmMin);
						pcm = walk[15:0];
						offer_item(pcm, 4'($urandom), 1'b0, '0);
					end else begin
						if (k < 6) nib = 4'($urandom_range(15));
						else if (k < 8) nib = $urandom_range(1) ? 4'd7 : 4'd15;
						else nib = 4'($urandom_range(3)) | ($urandom_range(1) ? 4'd8 : 4'd0);
						offer_item(16'($urandom), nib, 1'b0, '0);
					end
				end
			end
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (pending_results.size() != 0)
			flag_mismatch("results never delivered", 0, pending_results.size());
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ima_pkg.sv
rtl/ima_adpcm_codec.sv
rtl/ima_chk.sv
verif/tb_ima_adpcm_codec.sv
